// ===== rtl/lsfd_pkg.sv =====
// ============================================================================
// lsfd_pkg: shared types and constants of the sensor frame decoder
// Request/response structs, queue command, config view, codes.
// ============================================================================
`default_nettype none

package lsfd_pkg;

  localparam int unsigned MaxDevices = 4;
  localparam int unsigned SlotCount  = 4;
  localparam int unsigned FrameBytes = 16;
  localparam int unsigned UsedBytes  = 14;
  localparam int unsigned MinBytes   = 8;
  localparam int unsigned ThBytes    = 16;
  localparam int unsigned FogBytes   = 12;
  localparam int unsigned CountMax   = 31;

  localparam logic [7:0] StartByte = 8'h5e;
  localparam logic [7:0] TypeTh    = 8'hb0;
  localparam logic [7:0] TypeFog   = 8'hb1;
  localparam logic [7:0] LenTh     = 8'h06;
  localparam logic [7:0] LenFog    = 8'h02;
  localparam logic [7:0] FogClear  = 8'h01;

  localparam logic OpByte = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic KindReport  = 1'b0;
  localparam logic KindReadout = 1'b1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StShort    = 3'd1;
  localparam logic [2:0] StBadStart = 3'd2;
  localparam logic [2:0] StBadType  = 3'd3;
  localparam logic [2:0] StBadLen   = 3'd4;
  localparam logic [2:0] StBadSize  = 3'd5;

  localparam logic [1:0] SensNone = 2'd0;
  localparam logic [1:0] SensTh   = 2'd1;
  localparam logic [1:0] SensFog  = 2'd2;

  localparam logic [2:0] RegDevCount = 3'd0;
  localparam logic [2:0] RegDevAddr0 = 3'd1;
  localparam logic [2:0] RegDevAddr1 = 3'd2;
  localparam logic [2:0] RegDevAddr2 = 3'd3;
  localparam logic [2:0] RegDevAddr3 = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [31:0] now_seconds;
    logic [1:0]  record_slot;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  status;
    logic [1:0]  sensor_kind;
    logic [31:0] source_address;
    logic [3:0]  match_mask;
    logic [7:0]  voltage_tenths;
    logic        fog_present;
    logic [15:0] temperature_tenths;
    logic [15:0] humidity_tenths;
    logic [31:0] update_seconds;
  } out_rsp_t;

  typedef struct packed {
    logic        is_read;
    logic [1:0]  slot;
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  volt;
    logic        fog;
    logic [15:0] temp;
    logic [15:0] hum;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]             dev_count;
    logic [3:0][31:0]       dev_addr;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lsfd_front.sv =====
// ============================================================================
// lsfd_front: frame collector and classifier
// Stores frame bytes, checks the frame at its end, issues queue commands.
// ============================================================================
`default_nettype none

module lsfd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire lsfd_pkg::in_req_t req_i,
  output logic                  push_o,
  output lsfd_pkg::cmd_t        cmd_o
);

  logic [4:0] cnt_q, cnt_d;
  logic [7:0] store_q [lsfd_pkg::FrameBytes];
  logic [7:0] fb [lsfd_pkg::UsedBytes];
  logic [4:0] size;

  always_comb begin
    for (int i = 0; i < lsfd_pkg::UsedBytes; i++) begin
      fb[i] = (cnt_q == 5'(i)) ? req_i.data_byte : store_q[i];
    end
    size = (cnt_q == 5'(lsfd_pkg::CountMax)) ? cnt_q : cnt_q + 5'd1;
  end

  always_comb begin
    cmd_o = '0;
    if (req_i.operation == lsfd_pkg::OpRead) begin
      cmd_o.is_read = 1'b1;
      cmd_o.slot    = req_i.record_slot;
    end else begin
      cmd_o.status = lsfd_pkg::StOk;
      if (size < 5'(lsfd_pkg::MinBytes)) begin
        cmd_o.status = lsfd_pkg::StShort;
      end else if (fb[0] != lsfd_pkg::StartByte) begin
        cmd_o.status = lsfd_pkg::StBadStart;
      end else begin
        cmd_o.addr = {fb[1], fb[2], fb[3], fb[4]};
        if (fb[5] == lsfd_pkg::TypeTh) begin
          cmd_o.kind = lsfd_pkg::SensTh;
          if (fb[7] != lsfd_pkg::LenTh) begin
            cmd_o.status = lsfd_pkg::StBadLen;
          end else if (size != 5'(lsfd_pkg::ThBytes)) begin
            cmd_o.status = lsfd_pkg::StBadSize;
          end
        end else if (fb[5] == lsfd_pkg::TypeFog) begin
          cmd_o.kind = lsfd_pkg::SensFog;
          if (fb[7] != lsfd_pkg::LenFog) begin
            cmd_o.status = lsfd_pkg::StBadLen;
          end else if (size != 5'(lsfd_pkg::FogBytes)) begin
            cmd_o.status = lsfd_pkg::StBadSize;
          end
        end else begin
          cmd_o.status = lsfd_pkg::StBadType;
        end
      end
      if (cmd_o.status == lsfd_pkg::StOk) begin
        cmd_o.volt = fb[9];
        cmd_o.now  = req_i.now_seconds;
        if (cmd_o.kind == lsfd_pkg::SensFog) begin
          cmd_o.fog = (fb[8] != lsfd_pkg::FogClear);
        end else begin
          cmd_o.temp = {fb[10], fb[11]};
          cmd_o.hum  = {fb[12], fb[13]};
        end
      end
    end
  end

  assign push_o = accept_i &&
                  (req_i.operation == lsfd_pkg::OpRead || req_i.frame_end);

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i && req_i.operation == lsfd_pkg::OpByte) begin
      cnt_d = req_i.frame_end ? 5'd0 : size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && req_i.operation == lsfd_pkg::OpByte &&
        cnt_q < 5'(lsfd_pkg::FrameBytes)) begin
      store_q[cnt_q[3:0]] <= req_i.data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsfd_queue.sv =====
// ============================================================================
// lsfd_queue: two-entry command queue
// Decouples the frame front end from the record back end.
// ============================================================================
`default_nettype none

module lsfd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lsfd_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                empty_o,
  output lsfd_pkg::cmd_t      cmd_o
);

  lsfd_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsfd_back.sv =====
// ============================================================================
// lsfd_back: device record table and response register
// Matches addresses, updates records, serves readouts.
// ============================================================================
`default_nettype none

module lsfd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lsfd_pkg::cfg_t cfg_i,
  input  wire logic           empty_i,
  input  wire lsfd_pkg::cmd_t cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output lsfd_pkg::out_rsp_t  out_rsp_o
);

  logic [31:0] rec_time_q [lsfd_pkg::SlotCount];
  logic [7:0]  rec_volt_q [lsfd_pkg::SlotCount];
  logic        rec_fog_q  [lsfd_pkg::SlotCount];
  logic [15:0] rec_temp_q [lsfd_pkg::SlotCount];
  logic [15:0] rec_hum_q  [lsfd_pkg::SlotCount];

  logic                valid_q, valid_d;
  lsfd_pkg::out_rsp_t  rsp_q, rsp_d;
  logic [2:0]          inuse;
  logic [3:0]          mask;

  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    inuse = (cfg_i.dev_count > 3'(lsfd_pkg::MaxDevices)) ?
            3'(lsfd_pkg::MaxDevices) : cfg_i.dev_count;
    for (int i = 0; i < lsfd_pkg::SlotCount; i++) begin
      mask[i] = !cmd_i.is_read && cmd_i.status == lsfd_pkg::StOk &&
                3'(i) < inuse && cfg_i.dev_addr[i] == cmd_i.addr;
    end
  end

  always_comb begin
    rsp_d = '0;
    if (cmd_i.is_read) begin
      rsp_d.result_kind = lsfd_pkg::KindReadout;
      if ({1'b0, cmd_i.slot} < 3'(lsfd_pkg::MaxDevices)) begin
        rsp_d.source_address     = cfg_i.dev_addr[cmd_i.slot];
        rsp_d.voltage_tenths     = rec_volt_q[cmd_i.slot];
        rsp_d.fog_present        = rec_fog_q[cmd_i.slot];
        rsp_d.temperature_tenths = rec_temp_q[cmd_i.slot];
        rsp_d.humidity_tenths    = rec_hum_q[cmd_i.slot];
        rsp_d.update_seconds     = rec_time_q[cmd_i.slot];
      end
    end else begin
      rsp_d.result_kind        = lsfd_pkg::KindReport;
      rsp_d.status             = cmd_i.status;
      rsp_d.sensor_kind        = cmd_i.kind;
      rsp_d.source_address     = cmd_i.addr;
      rsp_d.match_mask         = mask;
      rsp_d.voltage_tenths     = cmd_i.volt;
      rsp_d.fog_present        = cmd_i.fog;
      rsp_d.temperature_tenths = cmd_i.temp;
      rsp_d.humidity_tenths    = cmd_i.hum;
      rsp_d.update_seconds     = cmd_i.now;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < lsfd_pkg::SlotCount; i++) begin
        rec_time_q[i] <= '0;
        rec_volt_q[i] <= '0;
        rec_fog_q[i]  <= 1'b0;
        rec_temp_q[i] <= '0;
        rec_hum_q[i]  <= '0;
      end
    end else begin
      valid_q <= valid_d;
      for (int i = 0; i < lsfd_pkg::SlotCount; i++) begin
        if (pop_o && mask[i]) begin
          rec_time_q[i] <= cmd_i.now;
          rec_volt_q[i] <= cmd_i.volt;
          if (cmd_i.kind == lsfd_pkg::SensFog) begin
            rec_fog_q[i] <= cmd_i.fog;
          end else begin
            rec_temp_q[i] <= cmd_i.temp;
            rec_hum_q[i]  <= cmd_i.hum;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/lora_sensor_frame_decoder_top.sv =====
// ============================================================================
// lora_sensor_frame_decoder_top: sensor frame decoder with device records
// Collects frame bytes, reports each frame, keeps four device records.
// ============================================================================
//  channel | dir | handshake                        | payload
//  in      | in  | in_valid_i / in_stall_o          | in_req_i  (in_req_t)
//  out     | out | out_valid_o / out_stall_i        | out_rsp_o (out_rsp_t)
//  cfg     | in  | psel/penable/pwrite, pready = 1  | paddr/pwdata/prdata
//
//  One request per cycle while in_stall_o is low; a report or readout is
//  queued once classified, then registered with its record update.
//  A two-entry queue sits between front and back; in_stall_o is its full flag.
//  Reset clears counters, records and config; the frame store is not cleared.
// ============================================================================
`default_nettype none

module lora_sensor_frame_decoder_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire lsfd_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output lsfd_pkg::out_rsp_t      out_rsp_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  lsfd_pkg::cfg_t cfg_q;
  logic           accept;
  logic           push, pop, full, empty;
  lsfd_pkg::cmd_t push_cmd, pop_cmd;
  logic           cfg_wr;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        lsfd_pkg::RegDevCount: cfg_q.dev_count   <= pwdata[2:0];
        lsfd_pkg::RegDevAddr0: cfg_q.dev_addr[0] <= pwdata;
        lsfd_pkg::RegDevAddr1: cfg_q.dev_addr[1] <= pwdata;
        lsfd_pkg::RegDevAddr2: cfg_q.dev_addr[2] <= pwdata;
        lsfd_pkg::RegDevAddr3: cfg_q.dev_addr[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lsfd_pkg::RegDevCount: prdata = {29'd0, cfg_q.dev_count};
      lsfd_pkg::RegDevAddr0: prdata = cfg_q.dev_addr[0];
      lsfd_pkg::RegDevAddr1: prdata = cfg_q.dev_addr[1];
      lsfd_pkg::RegDevAddr2: prdata = cfg_q.dev_addr[2];
      lsfd_pkg::RegDevAddr3: prdata = cfg_q.dev_addr[3];
      default:               prdata = '0;
    endcase
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  lsfd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  lsfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .cmd_o   (pop_cmd)
  );

  lsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  a_readout_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.result_kind == lsfd_pkg::KindReadout |->
      out_rsp_o.match_mask == 4'd0 && out_rsp_o.status == lsfd_pkg::StOk &&
      out_rsp_o.sensor_kind == lsfd_pkg::SensNone)
    else $error("readout carries report fields");

  a_failed_report_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.result_kind == lsfd_pkg::KindReport &&
      out_rsp_o.status != lsfd_pkg::StOk |->
      out_rsp_o.match_mask == 4'd0 && out_rsp_o.update_seconds == 32'd0)
    else $error("failed frame updated records");

  a_match_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.match_mask != 4'd0 |->
      out_rsp_o.status == lsfd_pkg::StOk &&
      out_rsp_o.sensor_kind != lsfd_pkg::SensNone)
    else $error("match without a good frame");

  a_queue_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full || pop)
    else $error("queue overflow");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the sensor frame decoder
// Streams frame bytes and record reads through the valid/stall request port,
// decodes each accepted request in a local model of the frame checks and the
// device record table, and compares every report/readout field by field.
// Device slots are reprogrammed over APB between phases while the block idles.
// ============================================================================

module tb_top;

  typedef enum int {
    FrmTh, FrmFog, FrmBadStart, FrmBadType, FrmBadLen, FrmBadSize, FrmShort
  } frame_shape_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  lsfd_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  lsfd_pkg::out_rsp_t out_rsp_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  lora_sensor_frame_decoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // decoder model state
  logic [2:0]  cfg_count;
  logic [31:0] cfg_addr [4];
  logic [7:0]  frame_bytes [lsfd_pkg::FrameBytes];
  int unsigned byte_total;
  logic [31:0] rec_time [4];
  logic [7:0]  rec_volt [4];
  logic        rec_fog [4];
  logic [15:0] rec_temp [4];
  logic [15:0] rec_hum [4];

  lsfd_pkg::in_req_t  queued_reqs [$];
  lsfd_pkg::out_rsp_t due_reports [$];
  int unsigned queued_items;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          pressure_armed;
  bit          pressure_done;
  int unsigned send_gap;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("[lora_sensor_frame_decoder_top] ERROR");
    $finish;
  end

  task automatic decode_request(input lsfd_pkg::in_req_t r);
    lsfd_pkg::out_rsp_t e;
    int unsigned        slots;
    e = '0;
    if (r.operation == lsfd_pkg::OpRead) begin
      e.result_kind        = lsfd_pkg::KindReadout;
      e.source_address     = cfg_addr[r.record_slot];
      e.voltage_tenths     = rec_volt[r.record_slot];
      e.fog_present        = rec_fog[r.record_slot];
      e.temperature_tenths = rec_temp[r.record_slot];
      e.humidity_tenths    = rec_hum[r.record_slot];
      e.update_seconds     = rec_time[r.record_slot];
      due_reports.push_back(e);
    end else begin
      if (byte_total < lsfd_pkg::FrameBytes) frame_bytes[byte_total[3:0]] = r.data_byte;
      if (byte_total < lsfd_pkg::CountMax) byte_total++;
      if (r.frame_end) begin
        e.result_kind = lsfd_pkg::KindReport;
        e.status      = lsfd_pkg::StOk;
        if (byte_total < lsfd_pkg::MinBytes) begin
          e.status = lsfd_pkg::StShort;
        end else if (frame_bytes[0] != lsfd_pkg::StartByte) begin
          e.status = lsfd_pkg::StBadStart;
        end else begin
          e.source_address = {frame_bytes[1], frame_bytes[2], frame_bytes[3],
                              frame_bytes[4]};
          if (frame_bytes[5] == lsfd_pkg::TypeTh) begin
            e.sensor_kind = lsfd_pkg::SensTh;
            if (frame_bytes[7] != lsfd_pkg::LenTh) e.status = lsfd_pkg::StBadLen;
            else if (byte_total != lsfd_pkg::ThBytes) e.status = lsfd_pkg::StBadSize;
          end else if (frame_bytes[5] == lsfd_pkg::TypeFog) begin
            e.sensor_kind = lsfd_pkg::SensFog;
            if (frame_bytes[7] != lsfd_pkg::LenFog) e.status = lsfd_pkg::StBadLen;
            else if (byte_total != lsfd_pkg::FogBytes) e.status = lsfd_pkg::StBadSize;
          end else begin
            e.status = lsfd_pkg::StBadType;
          end
        end
        if (e.status == lsfd_pkg::StOk) begin
          e.voltage_tenths = frame_bytes[9];
          e.update_seconds = r.now_seconds;
          if (e.sensor_kind == lsfd_pkg::SensFog) begin
            e.fog_present = (frame_bytes[8] != lsfd_pkg::FogClear);
          end else begin
            e.temperature_tenths = {frame_bytes[10], frame_bytes[11]};
            e.humidity_tenths    = {frame_bytes[12], frame_bytes[13]};
          end
          slots = (32'(cfg_count) > lsfd_pkg::MaxDevices) ? lsfd_pkg::MaxDevices :
                  32'(cfg_count);
          for (int i = 0; i < int'(slots); i++) begin
            if (cfg_addr[i] == e.source_address) begin
              e.match_mask[i] = 1'b1;
              rec_time[i]     = r.now_seconds;
              rec_volt[i]     = e.voltage_tenths;
              if (e.sensor_kind == lsfd_pkg::SensFog) begin
                rec_fog[i] = e.fog_present;
              end else begin
                rec_temp[i] = e.temperature_tenths;
                rec_hum[i]  = e.humidity_tenths;
              end
            end
          end
        end
        due_reports.push_back(e);
        byte_total = 0;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_report(input lsfd_pkg::out_rsp_t got);
    lsfd_pkg::out_rsp_t e;
    if (due_reports.size() == 0) begin
      $display("%0t: unexpected response, expected none actual %h", $time, got);
      fail_count++;
    end else begin
      e = due_reports.pop_front();
      check_field("result_kind", 32'(e.result_kind), 32'(got.result_kind));
      check_field("status", 32'(e.status), 32'(got.status));
      check_field("sensor_kind", 32'(e.sensor_kind), 32'(got.sensor_kind));
      check_field("source_address", e.source_address, got.source_address);
      check_field("match_mask", 32'(e.match_mask), 32'(got.match_mask));
      check_field("voltage_tenths", 32'(e.voltage_tenths), 32'(got.voltage_tenths));
      check_field("fog_present", 32'(e.fog_present), 32'(got.fog_present));
      check_field("temperature_tenths", 32'(e.temperature_tenths),
                  32'(got.temperature_tenths));
      check_field("humidity_tenths", 32'(e.humidity_tenths), 32'(got.humidity_tenths));
      check_field("update_seconds", e.update_seconds, got.update_seconds);
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_request(in_req_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (queued_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          in_req_i   <= queued_reqs.pop_front();
          if ($urandom_range(99) < send_idle_pct) send_gap = $urandom_range(1, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_report(out_rsp_o);
      if (pressure_armed && !pressure_done) begin
        pressure_done = 1'b1;
        stall_left    = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(99) < recv_idle_pct) begin
        stall_left = $urandom_range(2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lsfd_pkg::RegDevCount) cfg_count = val[2:0];
    else cfg_addr[2'(idx - lsfd_pkg::RegDevAddr0)] = val;
  endtask

  task automatic load_devices(input logic [2:0] count, input logic [31:0] a0,
                              input logic [31:0] a1, input logic [31:0] a2,
                              input logic [31:0] a3);
    write_reg(lsfd_pkg::RegDevCount, {29'd0, count});
    write_reg(lsfd_pkg::RegDevAddr0, a0);
    write_reg(lsfd_pkg::RegDevAddr1, a1);
    write_reg(lsfd_pkg::RegDevAddr2, a2);
    write_reg(lsfd_pkg::RegDevAddr3, a3);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    lsfd_pkg::in_req_t r;
    r.operation   = lsfd_pkg::OpByte;
    r.data_byte   = b;
    r.frame_end   = last;
    r.now_seconds = $urandom;
    r.record_slot = 2'($urandom_range(3));
    queued_reqs.push_back(r);
    queued_items++;
  endtask

  task automatic push_read(input logic [1:0] slot);
    lsfd_pkg::in_req_t r;
    r.operation   = lsfd_pkg::OpRead;
    r.data_byte   = 8'($urandom);
    r.frame_end   = 1'($urandom_range(1));
    r.now_seconds = $urandom;
    r.record_slot = slot;
    queued_reqs.push_back(r);
    queued_items++;
  endtask

  task automatic queue_frame(input frame_shape_e shape);
    logic [7:0]  fr [40];
    logic [31:0] a;
    int unsigned n;
    bit          fog;
    for (int i = 0; i < 40; i++) fr[i] = 8'($urandom);
    case ($urandom_range(7))
      0: a = 32'h0;
      1: a = 32'hffff_ffff;
      2: a = $urandom;
      default: a = cfg_addr[2'($urandom_range(3))];
    endcase
    fog = (shape == FrmFog) || (shape != FrmTh && $urandom_range(1) == 1);
    fr[0] = lsfd_pkg::StartByte;
    {fr[1], fr[2], fr[3], fr[4]} = a;
    fr[5] = fog ? lsfd_pkg::TypeFog : lsfd_pkg::TypeTh;
    fr[7] = fog ? lsfd_pkg::LenFog : lsfd_pkg::LenTh;
    n     = fog ? lsfd_pkg::FogBytes : lsfd_pkg::ThBytes;
    if (fog && $urandom_range(1) == 1) fr[8] = lsfd_pkg::FogClear;
    if ($urandom_range(7) == 0) begin
      for (int i = 9; i < 14; i++) fr[i] = 8'hff;
    end else if ($urandom_range(7) == 0) begin
      for (int i = 9; i < 14; i++) fr[i] = 8'h00;
    end
    case (shape)
      FrmBadStart: begin
        fr[0] = lsfd_pkg::StartByte ^ 8'($urandom_range(1, 255));
        n = $urandom_range(8, 16);
      end
      FrmBadType: begin
        if (fr[6] == lsfd_pkg::TypeTh || fr[6] == lsfd_pkg::TypeFog) fr[6] = fr[6] ^ 8'h40;
        fr[5] = fr[6];
        n = $urandom_range(8, 16);
      end
      FrmBadLen: begin
        fr[7] = fr[7] ^ 8'($urandom_range(1, 255));
        n = $urandom_range(8, 20);
      end
      FrmBadSize: begin
        if (n == $urandom_range(8, 40)) n = n + 1;
        else n = ($urandom_range(3) == 0) ? $urandom_range(32, 40) : $urandom_range(8, 24);
        if (n == (fog ? lsfd_pkg::FogBytes : lsfd_pkg::ThBytes)) n = n + 1;
      end
      FrmShort: n = $urandom_range(1, 7);
      default: ;
    endcase
    for (int i = 0; i < int'(n); i++) begin
      if ($urandom_range(19) == 0) push_read(2'($urandom_range(3)));
      push_byte(fr[i], i == int'(n) - 1);
    end
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = queued_items + count;
    while (queued_items < target) begin
      pick = $urandom_range(99);
      if (pick < 4) push_byte(8'($urandom), $urandom_range(7) == 0);
      else if (pick < 10) push_read(2'($urandom_range(3)));
      else if (pick < 38) queue_frame(FrmTh);
      else if (pick < 66) queue_frame(FrmFog);
      else if (pick < 72) queue_frame(FrmBadStart);
      else if (pick < 78) queue_frame(FrmBadType);
      else if (pick < 85) queue_frame(FrmBadLen);
      else if (pick < 93) queue_frame(FrmBadSize);
      else queue_frame(FrmShort);
    end
  endtask

  task automatic wait_drained(input int unsigned settle);
    @(negedge clk_i);
    while (queued_reqs.size() != 0 || in_valid_i || due_reports.size() != 0)
      @(negedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  fog_frame [lsfd_pkg::FogBytes];
    logic [31:0] ra;
    logic [31:0] rb;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    out_stall_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_count      = '0;
    byte_total     = 0;
    queued_items   = 0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    pressure_armed = 1'b0;
    pressure_done  = 1'b0;
    send_gap       = 0;
    stall_left     = 0;
    for (int i = 0; i < 4; i++) begin
      cfg_addr[i] = '0;
      rec_time[i] = '0;
      rec_volt[i] = '0;
      rec_fog[i]  = 1'b0;
      rec_temp[i] = '0;
      rec_hum[i]  = '0;
    end
    for (int i = 0; i < lsfd_pkg::FrameBytes; i++) frame_bytes[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // slot 0 and 3 share an address, so a match hits both
    load_devices(3'd4, 32'h1234_5678, 32'hffff_ffff, 32'h0000_0000, 32'h1234_5678);
    @(negedge clk_i);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    push_byte(8'hff, 1'b1);
    fog_frame = '{lsfd_pkg::StartByte, 8'h12, 8'h34, 8'h56, 8'h78, lsfd_pkg::TypeFog,
                  8'h00, lsfd_pkg::LenFog, 8'h03, 8'hff, 8'h00, 8'h00};
    for (int i = 0; i < lsfd_pkg::FogBytes; i++) begin
      if (i == 6) push_read(2'd2);
      push_byte(fog_frame[i], i == lsfd_pkg::FogBytes - 1);
    end
    push_read(2'd0);
    push_read(2'd3);
    for (int i = 0; i < lsfd_pkg::MinBytes; i++) push_byte(8'h00, i == lsfd_pkg::MinBytes - 1);
    queue_random(475);
    wait_drained(8);

    load_devices(3'd0, $urandom, $urandom, $urandom, $urandom);
    @(negedge clk_i);
    send_idle_pct = 40;
    recv_idle_pct = 40;
    queue_random(300);
    wait_drained(8);

    ra = $urandom;
    rb = $urandom;
    load_devices(3'd7, ra, rb, ra, $urandom);
    @(negedge clk_i);
    send_idle_pct  = 15;
    recv_idle_pct  = 15;
    pressure_armed = 1'b1;
    queue_random(600);
    wait_drained(8);

    load_devices(3'd2, 32'hffff_ffff, 32'h0000_0000, $urandom, $urandom);
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(550);
    wait_drained(20);

    if (due_reports.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, due_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[lora_sensor_frame_decoder_top] OK");
    end else begin
      $display("[lora_sensor_frame_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lsfd_pkg.sv
rtl/lsfd_front.sv
rtl/lsfd_queue.sv
rtl/lsfd_back.sv
rtl/lora_sensor_frame_decoder_top.sv
tb/tb_top.sv
